@@ hdl/sfp_pkg.sv @@
// Package for the swap pool FIFO pager: field widths, reset values,
// outcome codes, controller states and the command/status structs.
// No dependencies; sfp_ctrl, sfp_dp and the top level use it.
`default_nettype none

package sfp_pkg;

    localparam int POOL_FRAMES_DEF = 16;

    localparam int BASE_W  = 20;
    localparam int SPACE_W = 6;
    localparam int PAGE_W  = 5;
    localparam int FNUM_W  = 21;
    localparam int ENT_W   = SPACE_W + PAGE_W;

    localparam logic [BASE_W-1:0] BASE_RESET = 20'd8256;

    typedef enum logic [1:0] {
        OUT_TRAP   = 2'd0,
        OUT_RELOAD = 2'd1,
        OUT_FREE   = 2'd2,
        OUT_EVICT  = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VICT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan;
        logic vict_rd;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trap;
        logic scan_done;
        logic reload;
        logic full;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/sfp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/sfp_ctrl.sv @@
// Controller state machine of the swap pool FIFO pager.
// Depends on sfp_pkg for the state type and the command/status structs.
`default_nettype none

module sfp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire sfp_pkg::t_status i_st,
    output sfp_pkg::t_cmd         o_cmd,
    output logic                  o_idle
);

    sfp_pkg::t_state r_state;
    sfp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfp_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sfp_pkg::ST_SCAN;
            end
            sfp_pkg::ST_SCAN: begin
                priority if (i_st.trap) begin
                    n_state = sfp_pkg::ST_FINISH;
                end else if (i_st.scan_done) begin
                    if (i_st.reload || !i_st.full) n_state = sfp_pkg::ST_FINISH;
                    else n_state = sfp_pkg::ST_VICT;
                end else begin
                    n_state = sfp_pkg::ST_SCAN;
                end
            end
            sfp_pkg::ST_VICT: begin
                n_state = sfp_pkg::ST_FINISH;
            end
            sfp_pkg::ST_FINISH: begin
                if (i_st.out_free) n_state = sfp_pkg::ST_IDLE;
            end
            default: n_state = sfp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        unique case (r_state)
            sfp_pkg::ST_IDLE: begin
                o_idle         = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            sfp_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            sfp_pkg::ST_VICT: begin
                o_cmd.vict_rd = 1'b1;
            end
            sfp_pkg::ST_FINISH: begin
                o_cmd.finish = i_st.out_free;
            end
            default: o_idle = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/sfp_dp.sv @@
// Datapath of the swap pool FIFO pager: request and config registers,
// fill count, FIFO pointer, owner table scan and the result register.
// Depends on sfp_pkg and sfp_ram.
`default_nettype none

module sfp_dp #(
    parameter int POOL_FRAMES = sfp_pkg::POOL_FRAMES_DEF,
    localparam int FIDX_W = $clog2(POOL_FRAMES),
    localparam int FCNT_W = $clog2(POOL_FRAMES + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sfp_pkg::t_cmd                i_cmd,
    output sfp_pkg::t_status                  o_st,
    input  wire logic [sfp_pkg::SPACE_W-1:0]  i_space_id,
    input  wire logic [sfp_pkg::PAGE_W-1:0]   i_page_index,
    input  wire logic                         i_is_modification,
    input  wire logic                         i_entry_valid,
    input  wire logic                         i_cfg_valid,
    input  wire logic [sfp_pkg::BASE_W-1:0]   i_pool_base_frame,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [1:0]                        o_outcome,
    output logic [FIDX_W-1:0]                 o_frame_index,
    output logic [sfp_pkg::FNUM_W-1:0]        o_frame_number,
    output logic [sfp_pkg::SPACE_W-1:0]       o_victim_space_id,
    output logic [sfp_pkg::PAGE_W-1:0]        o_victim_page
);

    // Configuration and allocation state.
    logic [sfp_pkg::BASE_W-1:0]  r_base;
    logic [FCNT_W-1:0]           r_fill;
    logic [FIDX_W-1:0]           r_fifo;

    // Captured request.
    logic [sfp_pkg::SPACE_W-1:0] r_sp;
    logic [sfp_pkg::PAGE_W-1:0]  r_pg;
    logic                        r_modf;
    logic                        r_ev;

    // Scan state.
    logic [FCNT_W-1:0]           r_issue;
    logic                        r_cmp_vld;
    logic [FIDX_W-1:0]           r_cmp_idx;
    logic                        r_hit;
    logic [FIDX_W-1:0]           r_hit_idx;

    // Result register.
    logic                        r_out_vld;
    sfp_pkg::t_outcome           r_outcome;
    logic [FIDX_W-1:0]           r_fidx;
    logic [sfp_pkg::FNUM_W-1:0]  r_fnum;
    logic [sfp_pkg::SPACE_W-1:0] r_vsp;
    logic [sfp_pkg::PAGE_W-1:0]  r_vpg;

    logic                        issue_ok;
    logic                        match;
    logic                        full;
    logic                        reload;
    logic                        out_free;
    logic                        alloc;
    logic [FIDX_W-1:0]           pick;
    sfp_pkg::t_outcome           res_outcome;
    logic [FIDX_W-1:0]           res_fidx;
    logic [sfp_pkg::FNUM_W-1:0]  res_fnum;
    logic [sfp_pkg::SPACE_W-1:0] res_vsp;
    logic [sfp_pkg::PAGE_W-1:0]  res_vpg;

    logic                        ram_we;
    logic                        ram_re;
    logic [FIDX_W-1:0]           ram_waddr;
    logic [FIDX_W-1:0]           ram_raddr;
    logic [sfp_pkg::ENT_W-1:0]   ram_rdata;

    sfp_ram #(
        .WIDTH (sfp_pkg::ENT_W),
        .DEPTH (POOL_FRAMES)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_sp, r_pg}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Frames fill in order and are never freed, so the used frames are
    // exactly 0 .. r_fill-1 and the first free frame is r_fill.
    assign full     = (r_fill == FCNT_W'(POOL_FRAMES));
    assign reload   = r_hit && r_ev;
    assign out_free = !r_out_vld || !i_out_stall;
    assign issue_ok = (r_issue != r_fill) && !r_hit;
    assign match    = r_cmp_vld && (ram_rdata == {r_sp, r_pg});
    assign pick     = full ? r_fifo : r_fill[FIDX_W-1:0];
    assign alloc    = i_cmd.finish && !r_modf && !reload;

    assign ram_re    = (i_cmd.scan && issue_ok) || i_cmd.vict_rd;
    assign ram_raddr = i_cmd.vict_rd ? r_fifo : r_issue[FIDX_W-1:0];
    assign ram_we    = alloc;
    assign ram_waddr = pick;

    always_comb begin
        res_outcome = sfp_pkg::OUT_FREE;
        res_fidx    = pick;
        res_vsp     = '0;
        res_vpg     = '0;
        priority if (r_modf) begin
            res_outcome = sfp_pkg::OUT_TRAP;
            res_fidx    = '0;
        end else if (reload) begin
            res_outcome = sfp_pkg::OUT_RELOAD;
            res_fidx    = r_hit_idx;
        end else if (full) begin
            res_outcome = sfp_pkg::OUT_EVICT;
            res_vsp     = ram_rdata[sfp_pkg::ENT_W-1:sfp_pkg::PAGE_W];
            res_vpg     = ram_rdata[sfp_pkg::PAGE_W-1:0];
        end else begin
            res_outcome = sfp_pkg::OUT_FREE;
        end
        res_fnum = r_modf ? '0
                 : ({1'b0, r_base} + sfp_pkg::FNUM_W'(res_fidx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= sfp_pkg::BASE_RESET;
            r_fill    <= '0;
            r_fifo    <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_base <= i_pool_base_frame;

            if (i_cmd.load_req) begin
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else begin
                r_cmp_vld <= i_cmd.scan && issue_ok;
                if (i_cmd.scan && match && !r_hit) r_hit <= 1'b1;
            end

            if (alloc) begin
                if (full) begin
                    if (r_fifo == FIDX_W'(POOL_FRAMES - 1)) r_fifo <= '0;
                    else r_fifo <= r_fifo + 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end

            if (i_cmd.finish) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_sp    <= i_space_id;
            r_pg    <= i_page_index;
            r_modf  <= i_is_modification;
            r_ev    <= i_entry_valid;
            r_issue <= '0;
        end else if (i_cmd.scan && issue_ok) begin
            r_issue <= r_issue + 1'b1;
        end
        r_cmp_idx <= r_issue[FIDX_W-1:0];
        if (i_cmd.scan && match && !r_hit) r_hit_idx <= r_cmp_idx;
        if (i_cmd.finish) begin
            r_outcome <= res_outcome;
            r_fidx    <= res_fidx;
            r_fnum    <= res_fnum;
            r_vsp     <= res_vsp;
            r_vpg     <= res_vpg;
        end
    end

    always_comb begin
        o_st.trap      = r_modf;
        o_st.scan_done = r_hit || ((r_issue == r_fill) && !r_cmp_vld);
        o_st.reload    = reload;
        o_st.full      = full;
        o_st.out_free  = out_free;
    end

    assign o_out_valid       = r_out_vld;
    assign o_outcome         = r_outcome;
    assign o_frame_index     = r_fidx;
    assign o_frame_number    = r_fnum;
    assign o_victim_space_id = r_vsp;
    assign o_victim_page     = r_vpg;

endmodule

`default_nettype wire

@@ hdl/swap_pool_fifo_pager.sv @@
// Top level of the swap pool FIFO pager: page-fault handling over a swap
// pool with first-free allocation and FIFO replacement.
// Depends on sfp_pkg, sfp_ctrl, sfp_dp (which holds sfp_ram).
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+-------------------------------------
//  request  | i_in_valid  / o_in_stall       | space_id, page_index,
//           |                                | is_modification, entry_valid
//  result   | o_out_valid / i_out_stall      | outcome, frame_index, frame_number,
//           |                                | victim_space_id, victim_page
//  config   | i_cfg_valid / o_cfg_ready      | pool_base_frame
//
// A modification fault ends the scan at once and loads a trap result.
// Any other request scans the owner table one frame per cycle through the
// single read port of its RAM, over the frames in use (a hit ends the scan
// early), then reads the victim entry if it must evict.
// One request is in work at a time. The reset is synchronous and active
// low; it frees every frame, zeroes the FIFO pointer and loads the pool
// base with its reset value. No clearing pass is needed. A stalled result
// word sits in the output register while the next request is accepted and
// worked on; only its final load waits.
`default_nettype none

module swap_pool_fifo_pager #(
    parameter int POOL_FRAMES = sfp_pkg::POOL_FRAMES_DEF,
    localparam int FIDX_W = $clog2(POOL_FRAMES)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Request channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [sfp_pkg::SPACE_W-1:0]  i_space_id,
    input  wire logic [sfp_pkg::PAGE_W-1:0]   i_page_index,
    input  wire logic                         i_is_modification,
    input  wire logic                         i_entry_valid,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_outcome,
    output logic [FIDX_W-1:0]                 o_frame_index,
    output logic [sfp_pkg::FNUM_W-1:0]        o_frame_number,
    output logic [sfp_pkg::SPACE_W-1:0]       o_victim_space_id,
    output logic [sfp_pkg::PAGE_W-1:0]        o_victim_page,
    // Configuration write channel.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [sfp_pkg::BASE_W-1:0]   i_pool_base_frame
);

    sfp_pkg::t_cmd    cmd;
    sfp_pkg::t_status st;
    logic             idle;

    // The controller sequences capture, scan, victim read and result load.
    sfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    // The datapath owns the owner RAM and all data registers and computes the result word.
    sfp_dp #(
        .POOL_FRAMES (POOL_FRAMES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_st              (st),
        .i_space_id        (i_space_id),
        .i_page_index      (i_page_index),
        .i_is_modification (i_is_modification),
        .i_entry_valid     (i_entry_valid),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_pool_base_frame (i_pool_base_frame),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_outcome         (o_outcome),
        .o_frame_index     (o_frame_index),
        .o_frame_number    (o_frame_number),
        .o_victim_space_id (o_victim_space_id),
        .o_victim_page     (o_victim_page)
    );

    // New requests are taken only between requests.
    assign o_in_stall  = !idle;
    // The base register is only written while the block is idle.
    assign o_cfg_ready = idle;

    // A trap word carries no frame.
    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == sfp_pkg::OUT_TRAP))
        |-> (o_frame_number == '0) && (o_frame_index == '0))
        else $error("trap result carries a frame");

    // Only an eviction reports a victim.
    a_victim_only_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome != sfp_pkg::OUT_EVICT))
        |-> (o_victim_space_id == '0) && (o_victim_page == '0))
        else $error("victim reported without eviction");

    // Frames are never freed, so a full pool stays full.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.full |=> st.full)
        else $error("pool fill count went down");

    // A result word is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !cmd.finish)
        else $error("result loaded over a stalled word");

endmodule

`default_nettype wire
